### rtl/bcm_pkg.sv
package bcm_pkg;

  typedef enum logic [1:0] {
    REQ_CPU_WR = 2'd0,
    REQ_CPU_RD = 2'd1,
    REQ_PPU_RD = 2'd2,
    REQ_TICK   = 2'd3
  } req_e_t;

  typedef enum logic [2:0] {
    TGT_NONE     = 3'd0,
    TGT_PRG_ROM  = 3'd1,
    TGT_PRG_RAM  = 3'd2,
    TGT_CHR      = 3'd3,
    TGT_OPEN_BUS = 3'd4
  } target_e_t;

  // cpu address regions by addr[15:13]
  localparam logic [2:0] REGION_WINDOW   = 3'b011;
  localparam logic [2:0] REGION_CMD_SEL  = 3'b100;
  localparam logic [2:0] REGION_CMD_LOAD = 3'b101;

  // command register codes
  localparam logic [3:0] CMD_CHR_FIRST = 4'h0;
  localparam logic [3:0] CMD_CHR_LAST  = 4'h7;
  localparam logic [3:0] CMD_WINDOW    = 4'h8;
  localparam logic [3:0] CMD_PRG_FIRST = 4'h9;
  localparam logic [3:0] CMD_PRG_LAST  = 4'hB;
  localparam logic [3:0] CMD_MIRROR    = 4'hC;
  localparam logic [3:0] CMD_IRQ_CTRL  = 4'hD;
  localparam logic [3:0] CMD_CNT_LO    = 4'hE;
  localparam logic [3:0] CMD_CNT_HI    = 4'hF;

  // configuration register indexes
  localparam logic [1:0] REG_PRG_ROM_MASK = 2'd0;
  localparam logic [1:0] REG_PRG_RAM_MASK = 2'd1;
  localparam logic [1:0] REG_CHR_MASK     = 2'd2;

  localparam int CHR_SLOT_NUM = 8;
  localparam int PRG_SLOT_NUM = 3;

  typedef struct packed {
    logic [5:0] prg_rom_bank_mask;
    logic [5:0] prg_ram_bank_mask;
    logic [7:0] chr_bank_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] bus_addr;
    logic [7:0]  write_data;
    logic [7:0]  bus_hold_value;
  } item_t;

  typedef struct packed {
    logic [18:0] phys_addr;
    logic [2:0]  target;
    logic        ram_write;
    logic [7:0]  open_bus_data;
    logic [1:0]  mirroring;
    logic        irq_line;
  } result_t;

endpackage

### rtl/bcm_in_if.sv
interface bcm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] bus_addr;
  logic [7:0]  write_data;
  logic [7:0]  bus_hold_value;

  modport source (
    output valid, req_type, bus_addr, write_data, bus_hold_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, bus_addr, write_data, bus_hold_value,
    output ready
  );
endinterface

### rtl/bcm_out_if.sv
interface bcm_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] phys_addr;
  logic [2:0]  target;
  logic        ram_write;
  logic [7:0]  open_bus_data;
  logic [1:0]  mirroring;
  logic        irq_line;

  modport source (
    output valid, phys_addr, target, ram_write, open_bus_data, mirroring, irq_line,
    input  ready
  );

  modport sink (
    input  valid, phys_addr, target, ram_write, open_bus_data, mirroring, irq_line,
    output ready
  );
endinterface

### rtl/bcm_core.sv
module bcm_core #(
  parameter int PRG_BANK_BITS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_fire,
  input  bcm_pkg::item_t    item,
  input  bcm_pkg::cfg_t     cfg,
  output bcm_pkg::result_t  res
);

  localparam int FieldW = (PRG_BANK_BITS < 6) ? PRG_BANK_BITS : 6;
  localparam logic [5:0] BankFieldMask = 6'((1 << FieldW) - 1);

  logic [3:0]  command_sel_r, command_sel_nxt;
  logic [7:0]  chr_bank_r [bcm_pkg::CHR_SLOT_NUM];
  logic [7:0]  chr_bank_nxt [bcm_pkg::CHR_SLOT_NUM];
  logic [5:0]  prg_bank_r [bcm_pkg::PRG_SLOT_NUM];
  logic [5:0]  prg_bank_nxt [bcm_pkg::PRG_SLOT_NUM];
  logic [5:0]  window_bank_r, window_bank_nxt;
  logic        window_is_ram_r, window_is_ram_nxt;
  logic        window_ram_en_r, window_ram_en_nxt;
  logic [1:0]  mirror_mode_r, mirror_mode_nxt;
  logic        irq_enable_r, irq_enable_nxt;
  logic        count_enable_r, count_enable_nxt;
  logic [15:0] irq_counter_r, irq_counter_nxt;
  logic        irq_pending_r, irq_pending_nxt;

  logic [2:0]  region;
  logic [5:0]  win_ram_bank;
  logic [5:0]  win_rom_bank;
  logic [1:0]  prg_slot;
  logic [5:0]  prg_sel_bank;
  logic [2:0]  chr_slot;
  logic [5:0]  field_data;

  assign region       = item.bus_addr[15:13];
  assign win_ram_bank = window_bank_r & cfg.prg_ram_bank_mask;
  assign win_rom_bank = window_bank_r & cfg.prg_rom_bank_mask;
  assign prg_slot     = item.bus_addr[14:13];
  assign chr_slot     = item.bus_addr[12:10];
  assign field_data   = item.write_data[5:0] & BankFieldMask;

  always_comb begin
    if (prg_slot == 2'd3) begin
      prg_sel_bank = cfg.prg_rom_bank_mask;
    end else begin
      prg_sel_bank = prg_bank_r[prg_slot];
    end
  end

  always_comb begin
    command_sel_nxt   = command_sel_r;
    chr_bank_nxt      = chr_bank_r;
    prg_bank_nxt      = prg_bank_r;
    window_bank_nxt   = window_bank_r;
    window_is_ram_nxt = window_is_ram_r;
    window_ram_en_nxt = window_ram_en_r;
    mirror_mode_nxt   = mirror_mode_r;
    irq_enable_nxt    = irq_enable_r;
    count_enable_nxt  = count_enable_r;
    irq_counter_nxt   = irq_counter_r;
    irq_pending_nxt   = irq_pending_r;

    res               = '0;
    res.target        = bcm_pkg::TGT_NONE;

    case (item.req_type)
      bcm_pkg::REQ_CPU_WR: begin
        if (region == bcm_pkg::REGION_WINDOW) begin
          if (window_is_ram_r && window_ram_en_r) begin
            res.target    = bcm_pkg::TGT_PRG_RAM;
            res.ram_write = 1'b1;
            res.phys_addr = {win_ram_bank, item.bus_addr[12:0]};
          end
        end else if (region == bcm_pkg::REGION_CMD_SEL) begin
          command_sel_nxt = item.write_data[3:0];
        end else if (region == bcm_pkg::REGION_CMD_LOAD) begin
          case (command_sel_r) inside
            [bcm_pkg::CMD_CHR_FIRST:bcm_pkg::CMD_CHR_LAST]: begin
              chr_bank_nxt[command_sel_r[2:0]] = item.write_data;
            end
            bcm_pkg::CMD_WINDOW: begin
              window_bank_nxt   = field_data;
              window_is_ram_nxt = item.write_data[6];
              window_ram_en_nxt = item.write_data[7];
            end
            [bcm_pkg::CMD_PRG_FIRST:bcm_pkg::CMD_PRG_LAST]: begin
              prg_bank_nxt[2'(command_sel_r - bcm_pkg::CMD_PRG_FIRST)] = field_data;
            end
            bcm_pkg::CMD_MIRROR: begin
              mirror_mode_nxt = item.write_data[1:0];
            end
            bcm_pkg::CMD_IRQ_CTRL: begin
              irq_enable_nxt   = item.write_data[0];
              count_enable_nxt = item.write_data[7];
              irq_pending_nxt  = 1'b0;
            end
            bcm_pkg::CMD_CNT_LO: begin
              irq_counter_nxt = {irq_counter_r[15:8], item.write_data};
            end
            default: begin
              irq_counter_nxt = {item.write_data, irq_counter_r[7:0]};
            end
          endcase
        end
      end
      bcm_pkg::REQ_CPU_RD: begin
        if (region == bcm_pkg::REGION_WINDOW) begin
          if (!window_is_ram_r) begin
            res.target    = bcm_pkg::TGT_PRG_ROM;
            res.phys_addr = {win_rom_bank, item.bus_addr[12:0]};
          end else if (window_ram_en_r) begin
            res.target    = bcm_pkg::TGT_PRG_RAM;
            res.phys_addr = {win_ram_bank, item.bus_addr[12:0]};
          end else begin
            res.target        = bcm_pkg::TGT_OPEN_BUS;
            res.open_bus_data = item.bus_hold_value;
          end
        end else if (item.bus_addr[15]) begin
          res.target    = bcm_pkg::TGT_PRG_ROM;
          res.phys_addr = {prg_sel_bank & cfg.prg_rom_bank_mask, item.bus_addr[12:0]};
        end
      end
      bcm_pkg::REQ_PPU_RD: begin
        res.target    = bcm_pkg::TGT_CHR;
        res.phys_addr = {1'b0, chr_bank_r[chr_slot] & cfg.chr_bank_mask,
                         item.bus_addr[9:0]};
      end
      default: begin
        if (count_enable_r && !irq_pending_r) begin
          irq_counter_nxt = irq_counter_r - 16'd1;
          if ((irq_counter_r == 16'd0) && irq_enable_r) begin
            irq_pending_nxt = 1'b1;
          end
        end
      end
    endcase

    res.mirroring = mirror_mode_nxt;
    res.irq_line  = irq_pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      command_sel_r   <= '0;
      chr_bank_r      <= '{default: '0};
      prg_bank_r      <= '{default: '0};
      window_bank_r   <= '0;
      window_is_ram_r <= 1'b0;
      window_ram_en_r <= 1'b0;
      mirror_mode_r   <= '0;
      irq_enable_r    <= 1'b0;
      count_enable_r  <= 1'b0;
      irq_counter_r   <= '0;
      irq_pending_r   <= 1'b0;
    end else if (step_fire) begin
      command_sel_r   <= command_sel_nxt;
      chr_bank_r      <= chr_bank_nxt;
      prg_bank_r      <= prg_bank_nxt;
      window_bank_r   <= window_bank_nxt;
      window_is_ram_r <= window_is_ram_nxt;
      window_ram_en_r <= window_ram_en_nxt;
      mirror_mode_r   <= mirror_mode_nxt;
      irq_enable_r    <= irq_enable_nxt;
      count_enable_r  <= count_enable_nxt;
      irq_counter_r   <= irq_counter_nxt;
      irq_pending_r   <= irq_pending_nxt;
    end
  end

endmodule

### rtl/banked_cartridge_mapper_irq.sv
// Cartridge bank mapper with a down-counting interrupt timer. Each request on the input
// channel (cpu write, cpu read, ppu pattern read or cpu cycle tick) yields exactly one result
// carrying the translated address, its target memory, the ram write strobe, open bus data and
// the current mirroring and irq line as left by that request. A request is registered on
// entry, translated and applied to the mapper registers as it leaves the request register,
// and the result is held in an output register; one request is taken every clock while the
// result side keeps up. The bank masks are to be written over the apb port only while the
// block is idle; this is not enforced (0x0 prg rom mask, 0x4 prg ram mask, 0x8 chr mask).
module banked_cartridge_mapper_irq #(
  parameter int PRG_BANK_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  bcm_in_if.sink      in_chan,
  bcm_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bcm_pkg::cfg_t    cfg_r;
  bcm_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  bcm_pkg::result_t out_res_r;
  logic             out_valid_r;
  bcm_pkg::result_t step_res;

  logic             out_adv;
  logic             s1_fire;
  logic             in_fire;
  logic             cfg_wr;
  logic [1:0]       cfg_index;

  assign out_adv   = !out_valid_r || out_chan.ready;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_chan.ready = !s1_valid_r || out_adv;
  assign in_fire   = in_chan.valid && in_chan.ready;

  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_rom_bank_mask <= 6'd63;
      cfg_r.prg_ram_bank_mask <= 6'd0;
      cfg_r.chr_bank_mask     <= 8'd255;
    end else if (cfg_wr) begin
      case (cfg_index)
        bcm_pkg::REG_PRG_ROM_MASK: cfg_r.prg_rom_bank_mask <= cfg_pwdata[5:0];
        bcm_pkg::REG_PRG_RAM_MASK: cfg_r.prg_ram_bank_mask <= cfg_pwdata[5:0];
        bcm_pkg::REG_CHR_MASK:     cfg_r.chr_bank_mask     <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      bcm_pkg::REG_PRG_ROM_MASK: cfg_prdata = {26'd0, cfg_r.prg_rom_bank_mask};
      bcm_pkg::REG_PRG_RAM_MASK: cfg_prdata = {26'd0, cfg_r.prg_ram_bank_mask};
      bcm_pkg::REG_CHR_MASK:     cfg_prdata = {24'd0, cfg_r.chr_bank_mask};
      default:                   cfg_prdata = '0;
    endcase
  end

  // request register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.req_type       <= in_chan.req_type;
      s1_item_r.bus_addr       <= in_chan.bus_addr;
      s1_item_r.write_data     <= in_chan.write_data;
      s1_item_r.bus_hold_value <= in_chan.bus_hold_value;
    end
  end

  bcm_core #(
    .PRG_BANK_BITS (PRG_BANK_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_fire (s1_fire),
    .item      (s1_item_r),
    .cfg       (cfg_r),
    .res       (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= step_res;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.phys_addr     = out_res_r.phys_addr;
  assign out_chan.target        = out_res_r.target;
  assign out_chan.ram_write     = out_res_r.ram_write;
  assign out_chan.open_bus_data = out_res_r.open_bus_data;
  assign out_chan.mirroring     = out_res_r.mirroring;
  assign out_chan.irq_line      = out_res_r.irq_line;

endmodule
